// ===== rtl/tas_pkg.sv =====
// ----------------------------------------------------------------------------
// tas_pkg
// Shared types and constants of the thermal alarm supervisor: alarm numbers,
// configuration register indexes and widths, and the drive direction codes.
// ----------------------------------------------------------------------------
package tas_pkg;

    // Alarm numbers, also the bit positions in the masks
    localparam int NUM_ALARMS     = 4;
    localparam int ALARM_SENSOR   = 0;
    localparam int ALARM_HIGH     = 1;
    localparam int ALARM_LOW      = 2;
    localparam int ALARM_RESPONSE = 3;

    // Result field widths
    localparam int COUNT_W = 3;

    // Configuration registers
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ALARM_ENABLES   = 3'd0,
        CFG_HIGH_LIMIT      = 3'd1,
        CFG_LOW_LIMIT       = 3'd2,
        CFG_MIN_CHANGE      = 3'd3,
        CFG_TIMEOUT_SECONDS = 3'd4
    } cfg_index_t;

    localparam int ENABLES_W = 4;
    localparam int LIMIT_W   = 11;
    localparam int CHANGE_W  = 8;
    localparam int TIMEOUT_W = 17;

    // Reset values: 35.0, -5.0 and 0.5 degrees in 1/16 units, 90 minutes
    localparam logic [ENABLES_W-1:0]        ENABLES_RST = 4'hF;
    localparam logic signed [LIMIT_W-1:0]   HIGH_RST    = 11'sd560;
    localparam logic signed [LIMIT_W-1:0]   LOW_RST     = -11'sd80;
    localparam logic [CHANGE_W-1:0]         CHANGE_RST  = 8'd8;
    localparam logic [TIMEOUT_W-1:0]        TIMEOUT_RST = 17'd5400;

    // Timeout in milliseconds: 17 bits times 1000 fits in 27 bits
    localparam int MS_PER_S     = 1000;
    localparam int TIMEOUT_MS_W = 27;

    // Drive direction of the response tracker
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_COOL = 2'd1,
        DIR_HEAT = 2'd2
    } dir_t;

endpackage

// ===== rtl/tas_if.sv =====
// ----------------------------------------------------------------------------
// tas_if
// Valid/ready channels of the thermal alarm supervisor: the sample and
// acknowledge item going in, and the alarm summary item coming out.
// ----------------------------------------------------------------------------
interface tas_in_if
    import tas_pkg::*;
#(
    parameter int TEMP_WIDTH = 12,
    parameter int TIME_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic signed [TEMP_WIDTH-1:0] temperature;
    logic                         sample_valid;
    logic                         cooling_on;
    logic                         heating_on;
    logic [TIME_WIDTH-1:0]        now_ms;

    modport source (
        output valid, func, temperature, sample_valid, cooling_on, heating_on, now_ms,
        input  ready
    );

    modport sink (
        input  valid, func, temperature, sample_valid, cooling_on, heating_on, now_ms,
        output ready
    );
endinterface

interface tas_out_if
    import tas_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [NUM_ALARMS-1:0] active_mask;
    logic [NUM_ALARMS-1:0] unacked_mask;
    logic [COUNT_W-1:0]    active_count;
    logic                  any_unacked;
    logic [COUNT_W-1:0]    first_active;

    modport source (
        output valid, active_mask, unacked_mask, active_count, any_unacked, first_active,
        input  ready
    );

    modport sink (
        input  valid, active_mask, unacked_mask, active_count, any_unacked, first_active,
        output ready
    );
endinterface

// ===== rtl/thermal_alarm_supervisor.sv =====
// ----------------------------------------------------------------------------
// thermal_alarm_supervisor
// Latched temperature alarms with acknowledge and relay response watchdog.
//
// One item is taken per clock cycle while the output register is empty or
// being emptied. Each item updates the alarm state in the cycle it is
// accepted and its summary is held in the single output register on the
// next cycle; a new item is accepted while that summary waits, provided
// the consumer takes it in the same cycle. The response timeout compares
// the wrapped elapsed milliseconds against timeout_seconds * 1000, so no
// divider is involved. Configuration writes take effect at the next edge.
// ----------------------------------------------------------------------------
module thermal_alarm_supervisor
    import tas_pkg::*;
#(
    parameter int TEMP_WIDTH = 12,
    parameter int TIME_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    tas_in_if.sink                 sample_in,
    tas_out_if.source              status_out
);

    // Comparison widths
    localparam int LIM_CMP_W = (TEMP_WIDTH > LIMIT_W) ? TEMP_WIDTH : LIMIT_W;
    localparam int DELTA_W   = TEMP_WIDTH + 1;
    localparam int TIME_CMP_W = (TIME_WIDTH > TIMEOUT_MS_W) ? TIME_WIDTH : TIMEOUT_MS_W;

    // Configuration registers
    logic [ENABLES_W-1:0]        enables_reg;
    logic signed [LIMIT_W-1:0]   high_limit_reg;
    logic signed [LIMIT_W-1:0]   low_limit_reg;
    logic [CHANGE_W-1:0]         min_change_reg;
    logic [TIMEOUT_W-1:0]        timeout_reg;

    // Alarm and tracking state
    logic [NUM_ALARMS-1:0]        active_reg,  active_next;
    logic [NUM_ALARMS-1:0]        acked_reg,   acked_next;
    dir_t                         dir_reg,     dir_next;
    logic                         start_valid_reg, start_valid_next;
    logic signed [TEMP_WIDTH-1:0] start_temp_reg,  start_temp_next;
    logic [TIME_WIDTH-1:0]        start_time_reg,  start_time_next;

    // Output register
    logic                  out_valid_reg;
    logic [NUM_ALARMS-1:0] out_active_reg,  out_active_next;
    logic [NUM_ALARMS-1:0] out_unacked_reg, out_unacked_next;
    logic [COUNT_W-1:0]    out_count_reg,   out_count_next;
    logic                  out_any_reg,     out_any_next;
    logic [COUNT_W-1:0]    out_first_reg,   out_first_next;

    logic accept;

    // Working signals
    logic                         valid_s;
    logic signed [LIM_CMP_W-1:0]  temp_lim;
    logic signed [LIM_CMP_W-1:0]  high_ext;
    logic signed [LIM_CMP_W-1:0]  low_ext;
    logic signed [DELTA_W-1:0]    change;
    logic signed [DELTA_W-1:0]    min_change_ext;
    logic [TIME_WIDTH-1:0]        elapsed_ms;
    logic [TIME_CMP_W-1:0]        timeout_ms;
    dir_t                         drive_dir;
    logic [NUM_ALARMS-1:0]        want;

    // Take an item when the output register is empty or being emptied
    assign sample_in.ready = !out_valid_reg || status_out.ready;
    assign accept          = sample_in.valid && sample_in.ready;

    // Configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enables_reg    <= ENABLES_RST;
            high_limit_reg <= HIGH_RST;
            low_limit_reg  <= LOW_RST;
            min_change_reg <= CHANGE_RST;
            timeout_reg    <= TIMEOUT_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ALARM_ENABLES:   enables_reg    <= cfg_data[ENABLES_W-1:0];
                CFG_HIGH_LIMIT:      high_limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_LOW_LIMIT:       low_limit_reg  <= cfg_data[LIMIT_W-1:0];
                CFG_MIN_CHANGE:      min_change_reg <= cfg_data[CHANGE_W-1:0];
                CFG_TIMEOUT_SECONDS: timeout_reg    <= cfg_data[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // Widen operands for the limit, change and timeout compares
    always_comb
    begin
        valid_s        = sample_in.sample_valid;
        temp_lim       = LIM_CMP_W'(sample_in.temperature);
        high_ext       = LIM_CMP_W'(high_limit_reg);
        low_ext        = LIM_CMP_W'(low_limit_reg);
        min_change_ext = $signed({{(DELTA_W-CHANGE_W){1'b0}}, min_change_reg});
        elapsed_ms     = sample_in.now_ms - start_time_reg;
        timeout_ms     = TIME_CMP_W'(timeout_reg) * TIME_CMP_W'(MS_PER_S);

        // Cooling wins when both relays are on
        if (sample_in.cooling_on)
            drive_dir = DIR_COOL;
        else if (sample_in.heating_on)
            drive_dir = DIR_HEAT;
        else
            drive_dir = DIR_NONE;

        if (drive_dir == DIR_COOL)
            change = DELTA_W'(start_temp_reg) - DELTA_W'(sample_in.temperature);
        else
            change = DELTA_W'(sample_in.temperature) - DELTA_W'(start_temp_reg);
    end

    // Next alarm and tracking state for the item being taken
    always_comb
    begin
        active_next      = active_reg;
        acked_next       = acked_reg;
        dir_next         = dir_reg;
        start_valid_next = start_valid_reg;
        start_temp_next  = start_temp_reg;
        start_time_next  = start_time_reg;
        want             = active_reg;

        if (sample_in.func)
        begin
            // Acknowledge every active alarm
            acked_next = acked_reg | active_reg;
        end
        else
        begin
            want[ALARM_SENSOR] = enables_reg[ALARM_SENSOR] && !valid_s;
            want[ALARM_HIGH]   = enables_reg[ALARM_HIGH] && valid_s && (temp_lim > high_ext);
            want[ALARM_LOW]    = enables_reg[ALARM_LOW] && valid_s && (temp_lim < low_ext);

            if (!enables_reg[ALARM_RESPONSE] || !valid_s || drive_dir == DIR_NONE)
            begin
                // Drop tracking
                dir_next                 = DIR_NONE;
                start_valid_next         = 1'b0;
                start_temp_next          = '0;
                start_time_next          = '0;
                want[ALARM_RESPONSE]     = 1'b0;
            end
            else if (drive_dir != dir_reg || !start_valid_reg)
            begin
                // New direction: open a window at this sample
                dir_next             = drive_dir;
                start_valid_next     = 1'b1;
                start_temp_next      = sample_in.temperature;
                start_time_next      = sample_in.now_ms;
                want[ALARM_RESPONSE] = 1'b0;
            end
            else if (change >= min_change_ext)
            begin
                // Enough change: restart the window
                start_temp_next      = sample_in.temperature;
                start_time_next      = sample_in.now_ms;
                want[ALARM_RESPONSE] = 1'b0;
            end
            else
            begin
                want[ALARM_RESPONSE] = TIME_CMP_W'(elapsed_ms) >= timeout_ms;
            end

            // An alarm edge clears its acknowledge
            for (int i = 0; i < NUM_ALARMS; i++)
            begin
                if (want[i] != active_reg[i])
                begin
                    active_next[i] = want[i];
                    acked_next[i]  = 1'b0;
                end
            end
        end
    end

    // Summary of the new state
    always_comb
    begin
        out_active_next  = active_next;
        out_unacked_next = active_next & ~acked_next;
        out_any_next     = |out_unacked_next;
        out_count_next   = '0;
        out_first_next   = COUNT_W'(NUM_ALARMS);
        for (int i = NUM_ALARMS - 1; i >= 0; i--)
        begin
            if (active_next[i])
                out_first_next = COUNT_W'(i);
        end
        for (int i = 0; i < NUM_ALARMS; i++)
        begin
            out_count_next = out_count_next + COUNT_W'(active_next[i]);
        end
    end

    // Hold the alarm state, advance on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= '0;
            acked_reg       <= '0;
            dir_reg         <= DIR_NONE;
            start_valid_reg <= 1'b0;
            start_temp_reg  <= '0;
            start_time_reg  <= '0;
        end
        else if (accept)
        begin
            active_reg      <= active_next;
            acked_reg       <= acked_next;
            dir_reg         <= dir_next;
            start_valid_reg <= start_valid_next;
            start_temp_reg  <= start_temp_next;
            start_time_reg  <= start_time_next;
        end
    end

    // Output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (sample_in.ready)
            out_valid_reg <= sample_in.valid;
    end

    // Output payload, loaded with each accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_active_reg  <= out_active_next;
            out_unacked_reg <= out_unacked_next;
            out_count_reg   <= out_count_next;
            out_any_reg     <= out_any_next;
            out_first_reg   <= out_first_next;
        end
    end

    assign status_out.valid        = out_valid_reg;
    assign status_out.active_mask  = out_active_reg;
    assign status_out.unacked_mask = out_unacked_reg;
    assign status_out.active_count = out_count_reg;
    assign status_out.any_unacked  = out_any_reg;
    assign status_out.first_active = out_first_reg;

endmodule
